// ----- sv/ttcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttcb_pkg: shared types and constants of the terminal cell buffer
// operation codes, character codes, field widths and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

   // build-time defaults of the store geometry
   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 64;

   // fixed field widths
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 8;
   localparam int TROW_W     = 7;
   localparam int OUT_ROW_W  = 6;
   localparam int CFG_COLS_W = 8;
   localparam int CFG_ROWS_W = 7;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ROWS = 1'b1;

   // register reset values
   localparam logic [CFG_COLS_W-1:0] ACTIVE_COLS_RST = 8'd80;
   localparam logic [CFG_ROWS_W-1:0] ACTIVE_ROWS_RST = 7'd30;

   // character codes
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
   localparam logic [CHAR_W-1:0] NUL_CODE     = 8'h00;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_PUT,
      ST_CLEAR,
      ST_FINISH
   } seq_state_type;

endpackage

`default_nettype wire

// ----- sv/ttcb_if.sv -----
// ----------------------------------------------------------------------------
// ttcb_if: request and response channels of the terminal cell buffer
// valid/ready channels carrying one operation and one result
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcb_req_if import ttcb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   op_type               operation;
   logic [CHAR_W-1:0]    char_code;
   logic [COL_W-1:0]     target_col;
   logic [TROW_W-1:0]    target_row;

   modport source (output valid, operation, char_code, target_col, target_row,
                   input ready);
   modport sink   (input valid, operation, char_code, target_col, target_row,
                   output ready);
endinterface

interface ttcb_rsp_if import ttcb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COL_W-1:0]     cur_col;
   logic [OUT_ROW_W-1:0] cur_row;
   logic [CHAR_W-1:0]    cell_value;
   logic                 scrolled;

   modport source (output valid, cur_col, cur_row, cell_value, scrolled,
                   input ready);
   modport sink   (input valid, cur_col, cur_row, cell_value, scrolled,
                   output ready);
endinterface

`default_nettype wire

// ----- sv/ttcb_store.sv -----
// ----------------------------------------------------------------------------
// ttcb_store: cell memory
// one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_store import ttcb_pkg::*; #(
   parameter int DEPTH  = MAX_COLS_DEF * MAX_ROWS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              write_en,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [CHAR_W-1:0] write_data,
   input  wire logic              read_en,
   input  wire logic [ADDR_W-1:0] read_addr,
   output      logic [CHAR_W-1:0] read_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ----- sv/ttcb_seq.sv -----
// ----------------------------------------------------------------------------
// ttcb_seq: operation sequencer of the terminal cell buffer
// cursor, scroll and clear sweeps over the cell memory, result register
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_seq import ttcb_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int DEPTH    = MAX_COLS * MAX_ROWS,
   parameter int ADDR_W   = $clog2(DEPTH),
   parameter int CIDX_W   = $clog2(MAX_COLS),
   parameter int ROW_W    = $clog2(MAX_ROWS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CIDX_W:0]   eff_cols,
   input  wire logic [ROW_W:0]    eff_rows,
   ttcb_req_if.sink               req,
   ttcb_rsp_if.source             rsp,
   output      logic              mem_we,
   output      logic [ADDR_W-1:0] mem_waddr,
   output      logic [CHAR_W-1:0] mem_wdata,
   output      logic              mem_re,
   output      logic [ADDR_W-1:0] mem_raddr,
   input  wire logic [CHAR_W-1:0] mem_rdata
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_COLS);

   seq_state_type        state_ff, state_in;
   op_type               op_ff, op_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [COL_W-1:0]     tcol_ff, tcol_in;
   logic [TROW_W-1:0]    trow_ff, trow_in;
   logic [COL_W-1:0]     cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]     cursor_row_ff, cursor_row_in;
   logic [CIDX_W-1:0]    scan_col_ff, scan_col_in;
   logic [ROW_W-1:0]     scan_row_ff, scan_row_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 put_pend_ff, put_pend_in;
   logic                 scrolled_ff, scrolled_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]     rsp_col_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [CHAR_W-1:0]    rsp_value_ff;
   logic                 rsp_scrolled_ff;

   logic                 out_free;
   logic                 load_out;
   logic                 finish;
   logic [ROW_W:0]       row_inc;
   logic                 row_over;
   logic [ROW_W-1:0]     last_row;
   logic                 in_area;
   logic                 last_col;
   logic                 last_copy_row;
   logic [COL_W-1:0]     tgt_col;
   logic [TROW_W-1:0]    tgt_row;
   logic [ADDR_W-1:0]    cur_addr;
   logic [ADDR_W-1:0]    tgt_addr;
   logic [ROW_W:0]       rows_less1;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0]  r,
                                                   input logic [CIDX_W-1:0] c);
      return ADDR_W'(r) * ROW_STEP + ADDR_W'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         clr_ff        <= '0;
         put_pend_ff   <= 1'b0;
         scrolled_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         clr_ff        <= clr_in;
         put_pend_ff   <= put_pend_in;
         scrolled_ff   <= scrolled_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      char_ff     <= char_in;
      tcol_ff     <= tcol_in;
      trow_ff     <= trow_in;
      scan_col_ff <= scan_col_in;
      scan_row_ff <= scan_row_in;
      base_ff     <= base_in;
      if (load_out) begin
         rsp_col_ff      <= cursor_col_in;
         rsp_row_ff      <= OUT_ROW_W'(cursor_row_in);
         rsp_value_ff    <= (op_ff == OP_READ) ? mem_rdata : NUL_CODE;
         rsp_scrolled_ff <= scrolled_in;
      end
   end

   // shared address and compare terms
   always_comb begin
      row_inc       = {1'b0, cursor_row_ff} + 1'b1;
      row_over      = (row_inc >= eff_rows);
      rows_less1    = eff_rows - 1'b1;
      last_row      = rows_less1[ROW_W-1:0];
      in_area       = ({1'b0, cursor_row_ff} < eff_rows) && (cursor_col_ff < eff_cols);
      last_col      = (({1'b0, scan_col_ff} + 1'b1) == eff_cols);
      last_copy_row = (({1'b0, scan_row_ff} + 2'd2) == eff_rows);
      tgt_col       = (tcol_ff < eff_cols) ? tcol_ff : '0;
      tgt_row       = (trow_ff < eff_rows) ? trow_ff : '0;
      cur_addr      = cell_addr(cursor_row_ff, cursor_col_ff[CIDX_W-1:0]);
      tgt_addr      = cell_addr(tgt_row[ROW_W-1:0], tgt_col[CIDX_W-1:0]);
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      char_in       = char_ff;
      tcol_in       = tcol_ff;
      trow_in       = trow_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      scan_col_in   = scan_col_ff;
      scan_row_in   = scan_row_ff;
      base_in       = base_ff;
      clr_in        = clr_ff;
      put_pend_in   = put_pend_ff;
      scrolled_in   = scrolled_ff;
      finish        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cur_addr;
      mem_wdata     = SPACE_CODE;
      mem_re        = 1'b0;
      mem_raddr     = tgt_addr;
      out_free      = !rsp_valid_ff || rsp.ready;

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               op_in       = req.operation;
               char_in     = req.char_code;
               tcol_in     = req.target_col;
               trow_in     = req.target_row;
               scrolled_in = 1'b0;
               put_pend_in = 1'b0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_PUT: begin
                  if (char_ff == NUL_CODE) begin
                     finish = 1'b1;
                  end else if (char_ff == NEWLINE_CODE || cursor_col_ff >= eff_cols) begin
                     cursor_col_in = '0;
                     if (row_over) begin
                        cursor_row_in = last_row;
                        scrolled_in   = 1'b1;
                        put_pend_in   = (char_ff != NEWLINE_CODE);
                        scan_col_in   = '0;
                        scan_row_in   = '0;
                        base_in       = '0;
                        // a single row has nothing to copy
                        state_in      = (eff_rows == 1) ? ST_BLANK : ST_SCROLL_RD;
                     end else begin
                        cursor_row_in = row_inc[ROW_W-1:0];
                        if (char_ff == NEWLINE_CODE) begin
                           finish = 1'b1;
                        end else begin
                           state_in = ST_PUT;
                        end
                     end
                  end else begin
                     mem_we        = ({1'b0, cursor_row_ff} < eff_rows);
                     mem_wdata     = char_ff;
                     cursor_col_in = cursor_col_ff + 1'b1;
                     finish        = 1'b1;
                  end
               end
               OP_SET: begin
                  cursor_col_in = tgt_col;
                  cursor_row_in = tgt_row[ROW_W-1:0];
                  finish        = 1'b1;
               end
               OP_CLEAR: begin
                  cursor_col_in = '0;
                  cursor_row_in = '0;
                  clr_in        = '0;
                  state_in      = ST_CLEAR;
               end
               OP_READ: begin
                  mem_re   = 1'b1;
                  state_in = ST_FINISH;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_SCROLL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = base_ff + ROW_STEP + ADDR_W'(scan_col_ff);
            state_in  = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + ADDR_W'(scan_col_ff);
            mem_wdata = mem_rdata;
            state_in  = ST_SCROLL_RD;
            if (last_col) begin
               scan_col_in = '0;
               base_in     = base_ff + ROW_STEP;
               if (last_copy_row) begin
                  state_in = ST_BLANK;
               end else begin
                  scan_row_in = scan_row_ff + 1'b1;
               end
            end else begin
               scan_col_in = scan_col_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + ADDR_W'(scan_col_ff);
            if (last_col) begin
               scan_col_in = '0;
               if (put_pend_ff) begin
                  state_in = ST_PUT;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               scan_col_in = scan_col_ff + 1'b1;
            end
         end
         ST_PUT: begin
            mem_we        = in_area;
            mem_wdata     = char_ff;
            cursor_col_in = cursor_col_ff + 1'b1;
            finish        = 1'b1;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               finish = 1'b1;
            end
         end
         ST_FINISH: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the result over, or hold it in the finish state
      load_out = finish && out_free;
      if (finish) begin
         state_in = out_free ? ST_IDLE : ST_FINISH;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.cur_col    = rsp_col_ff;
   assign rsp.cur_row    = rsp_row_ff;
   assign rsp.cell_value = rsp_value_ff;
   assign rsp.scrolled   = rsp_scrolled_ff;

`ifndef NO_ASSERTIONS
   a_no_result_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !rsp_valid_ff)
      else $error("result raised during the initial clearing pass");

   a_transfer_starts_exec: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start execution");

   a_copy_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL_WR) |-> ($past(state_ff) == ST_SCROLL_RD))
      else $error("scroll copy without a preceding read");

   a_scroll_flag_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL_RD || state_ff == ST_BLANK) |-> scrolled_ff)
      else $error("scroll pass without the scrolled flag");
`endif

endmodule

`default_nettype wire

// ----- sv/text_terminal_cell_buffer_top.sv -----
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer_top: character-cell terminal store with a cursor
// put, set and newline finish in the execute state, read passes the finish state and a put with
// wrap the put state; scroll and clear sweeps are bound by the single memory write port
// after reset a clearing pass over all MAX_COLS*MAX_ROWS cells runs before the first transfer
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cell_buffer_top import ttcb_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ttcb_req_if.sink                   req_chan,
   ttcb_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   // geometry of the cell memory: cell (r,c) sits at r*MAX_COLS+c
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CIDX_W = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);

   logic [CFG_COLS_W-1:0] active_cols_ff;
   logic [CFG_ROWS_W-1:0] active_rows_ff;
   logic [CIDX_W:0]       eff_cols;
   logic [ROW_W:0]        eff_rows;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CHAR_W-1:0] mem_rdata;

   // configuration registers; write them only while the block is idle (not enforced by the block)
   always_ff @(posedge clock) begin
      if (reset) begin
         active_cols_ff <= ACTIVE_COLS_RST;
         active_rows_ff <= ACTIVE_ROWS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACTIVE_COLS: active_cols_ff <= csr_write_data;
            CSR_ACTIVE_ROWS: active_rows_ff <= csr_write_data[CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry: zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (active_cols_ff == '0) begin
         eff_cols = (CIDX_W + 1)'(1);
      end else if (active_cols_ff > MAX_COLS) begin
         eff_cols = (CIDX_W + 1)'(MAX_COLS);
      end else begin
         eff_cols = (CIDX_W + 1)'(active_cols_ff);
      end

      if (active_rows_ff == '0) begin
         eff_rows = (ROW_W + 1)'(1);
      end else if (active_rows_ff > MAX_ROWS) begin
         eff_rows = (ROW_W + 1)'(MAX_ROWS);
      end else begin
         eff_rows = (ROW_W + 1)'(active_rows_ff);
      end
   end

   // sequencer: cursor, result register and the scroll/clear sweeps
   ttcb_seq #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .DEPTH    (DEPTH),
      .ADDR_W   (ADDR_W),
      .CIDX_W   (CIDX_W),
      .ROW_W    (ROW_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .eff_cols  (eff_cols),
      .eff_rows  (eff_rows),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // cell memory, one byte per cell, read data registered
   ttcb_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .write_en   (mem_we),
      .write_addr (mem_waddr),
      .write_data (mem_wdata),
      .read_en    (mem_re),
      .read_addr  (mem_raddr),
      .read_data  (mem_rdata)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the terminal cell buffer
// mirrors the cell store and cursor in a scoreboard, drives put, set, clear
// and read transfers through directed and random phases at several screen
// geometries with random source gaps and sink stalls, and checks every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb import ttcb_pkg::*; ();

   // pause after the last expected result before a register write or the end
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 64;
   // longest correct quiet stretch is a full-size scroll of the whole store
   localparam int WATCHDOG_LIMIT = 100000;

   typedef struct packed {
      op_type              operation;
      logic [CHAR_W-1:0]   char_code;
      logic [COL_W-1:0]    target_col;
      logic [TROW_W-1:0]   target_row;
   } cell_request_type;

   typedef struct packed {
      logic [COL_W-1:0]     cur_col;
      logic [OUT_ROW_W-1:0] cur_row;
      logic [CHAR_W-1:0]    cell_value;
      logic                 scrolled;
   } cursor_report_type;

   // mirror of the screen: cell store, cursor and geometry registers,
   // plus the queue of cursor reports still owed by the block
   class screen_mirror;
      logic [CHAR_W-1:0]     cells [MAX_COLS_DEF*MAX_ROWS_DEF];
      int                    col_pos;
      int                    row_pos;
      logic [CFG_COLS_W-1:0] cols_reg;
      logic [CFG_ROWS_W-1:0] rows_reg;
      cursor_report_type     awaited_reports [$];
      int                    mismatches;

      function new();
         blank_all();
         col_pos    = 0;
         row_pos    = 0;
         cols_reg   = ACTIVE_COLS_RST;
         rows_reg   = ACTIVE_ROWS_RST;
         mismatches = 0;
      endfunction

      function void blank_all();
         foreach (cells[i]) cells[i] = SPACE_CODE;
      endfunction

      // zero acts as one, anything above the store size acts as the maximum
      function int width_in_use();
         if (cols_reg == 0) return 1;
         if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
         return cols_reg;
      endfunction

      function int height_in_use();
         if (rows_reg == 0) return 1;
         if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
         return rows_reg;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_ACTIVE_COLS) cols_reg = value[CFG_COLS_W-1:0];
         else rows_reg = value[CFG_ROWS_W-1:0];
      endfunction

      // column 0 of the next row, scrolling the active area when it falls off
      function bit advance_line(int cols, int rows);
         col_pos = 0;
         row_pos++;
         if (row_pos < rows) return 1'b0;
         for (int r = 0; r + 1 < rows; r++)
            for (int c = 0; c < cols; c++)
               cells[r*MAX_COLS_DEF + c] = cells[(r+1)*MAX_COLS_DEF + c];
         for (int c = 0; c < cols; c++)
            cells[(rows-1)*MAX_COLS_DEF + c] = SPACE_CODE;
         row_pos = rows - 1;
         return 1'b1;
      endfunction

      function void note_request(cell_request_type rq);
         int                cols;
         int                rows;
         int                c;
         int                r;
         cursor_report_type due;
         cols           = width_in_use();
         rows           = height_in_use();
         due.cell_value = '0;
         due.scrolled   = 1'b0;
         case (rq.operation)
            OP_PUT: begin
               if (rq.char_code == NEWLINE_CODE) begin
                  due.scrolled = advance_line(cols, rows);
               end else if (rq.char_code != NUL_CODE) begin
                  // deferred wrap, then store only inside the active area
                  if (col_pos >= cols) due.scrolled = advance_line(cols, rows);
                  if (row_pos < rows && col_pos < cols)
                     cells[row_pos*MAX_COLS_DEF + col_pos] = rq.char_code;
                  col_pos++;
               end
            end
            OP_SET: begin
               col_pos = (rq.target_col < cols) ? int'(rq.target_col) : 0;
               row_pos = (rq.target_row < rows) ? int'(rq.target_row) : 0;
            end
            OP_CLEAR: begin
               blank_all();
               col_pos = 0;
               row_pos = 0;
            end
            default: begin
               c = (rq.target_col < cols) ? int'(rq.target_col) : 0;
               r = (rq.target_row < rows) ? int'(rq.target_row) : 0;
               due.cell_value = cells[r*MAX_COLS_DEF + c];
            end
         endcase
         due.cur_col = COL_W'(col_pos);
         due.cur_row = OUT_ROW_W'(row_pos);
         awaited_reports.push_back(due);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
         if (want !== seen) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
         end
      endfunction

      function void check_report(cursor_report_type got);
         cursor_report_type due;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none actual col %0d row %0d value %0d",
                     $time, got.cur_col, got.cur_row, got.cell_value);
            return;
         end
         due = awaited_reports.pop_front();
         compare_field("cur_col", due.cur_col, got.cur_col);
         compare_field("cur_row", 8'(due.cur_row), 8'(got.cur_row));
         compare_field("cell_value", due.cell_value, got.cell_value);
         compare_field("scrolled", 8'(due.scrolled), 8'(got.scrolled));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   ttcb_req_if req_chan ();
   ttcb_rsp_if rsp_chan ();

   screen_mirror screen = new();

   // percentages of cycles in which the source holds back or the sink stalls
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;

   text_terminal_cell_buffer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sink side: ready drops at random according to the current phase
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // transfer monitor and watchdog, sampling values from before the edge
   always @(posedge clock) begin
      cell_request_type  seen_req;
      cursor_report_type seen_rsp;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_req.operation  = req_chan.operation;
            seen_req.char_code  = req_chan.char_code;
            seen_req.target_col = req_chan.target_col;
            seen_req.target_row = req_chan.target_row;
            screen.note_request(seen_req);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp.cur_col    = rsp_chan.cur_col;
            seen_rsp.cur_row    = rsp_chan.cur_row;
            seen_rsp.cell_value = rsp_chan.cell_value;
            seen_rsp.scrolled   = rsp_chan.scrolled;
            screen.check_report(seen_rsp);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         // nothing moving for far longer than any scroll or clear can take
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic cell_request_type request_of(op_type op, int ch, int col, int row);
      cell_request_type rq;
      rq.operation  = op;
      rq.char_code  = CHAR_W'(ch);
      rq.target_col = COL_W'(col);
      rq.target_row = TROW_W'(row);
      return rq;
   endfunction

   // mostly puts of random character codes with newlines, some cursor moves and reads, rare
   // clears since each one walks the whole store
   function automatic cell_request_type random_request(int clear_pct, int newline_pct);
      cell_request_type rq;
      int               pick;
      int               cols;
      int               rows;
      cols = screen.width_in_use();
      rows = screen.height_in_use();
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) rq.operation = OP_CLEAR;
      else if (pick < clear_pct + 15) rq.operation = OP_SET;
      else if (pick < clear_pct + 35) rq.operation = OP_READ;
      else rq.operation = OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) rq.char_code = NEWLINE_CODE;
      else if (pick < newline_pct + 3) rq.char_code = NUL_CODE;
      else rq.char_code = CHAR_W'($urandom_range(1, 255));
      // targets mostly inside or just on the edge of the active area
      if ($urandom_range(0, 3) == 0) begin
         rq.target_col = COL_W'($urandom);
         rq.target_row = TROW_W'($urandom);
      end else begin
         rq.target_col = COL_W'($urandom_range(0, cols));
         rq.target_row = TROW_W'($urandom_range(0, rows));
      end
      return rq;
   endfunction

   // one request transfer; valid stays high into the next call when no gap
   task automatic send_request(cell_request_type rq);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= rq.operation;
      req_chan.char_code  <= rq.char_code;
      req_chan.target_col <= rq.target_col;
      req_chan.target_row <= rq.target_row;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (screen.awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both geometry registers on back-to-back cycles, block idle
   task automatic program_geometry(logic [CSR_DATA_W-1:0] cols_val,
                                   logic [CSR_DATA_W-1:0] rows_val);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ACTIVE_COLS;
      csr_write_data   <= cols_val;
      @(posedge clock);
      screen.write_register(CSR_ACTIVE_COLS, cols_val);
      csr_index        <= CSR_ACTIVE_ROWS;
      csr_write_data   <= rows_val;
      @(posedge clock);
      screen.write_register(CSR_ACTIVE_ROWS, rows_val);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] cols_val, logic [CSR_DATA_W-1:0] rows_val,
                            int count, int clear_pct, int newline_pct,
                            int idle_pct, int stall_pct);
      wait_until_drained();
      program_geometry(cols_val, rows_val);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_request(random_request(clear_pct, newline_pct));
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.operation  = OP_PUT;
      req_chan.char_code  = '0;
      req_chan.target_col = '0;
      req_chan.target_row = '0;
      rsp_chan.ready      = 1'b0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_ACTIVE_COLS;
      csr_write_data      = '0;
      reset               = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset geometry of 80 by 30
      send_request(request_of(OP_READ, 0, 0, 0));
      send_request(request_of(OP_PUT, 8'h41, 0, 0));
      send_request(request_of(OP_PUT, NUL_CODE, 0, 0));       // terminator, no effect
      send_request(request_of(OP_PUT, 8'hff, 0, 0));
      send_request(request_of(OP_READ, 0, 1, 0));
      send_request(request_of(OP_SET, 0, 79, 29));            // bottom right corner
      send_request(request_of(OP_PUT, 8'h5a, 0, 0));          // column rests past the edge
      send_request(request_of(OP_READ, 0, 79, 29));
      send_request(request_of(OP_PUT, 8'h51, 0, 0));          // deferred wrap then scroll
      send_request(request_of(OP_READ, 0, 79, 28));
      send_request(request_of(OP_PUT, NEWLINE_CODE, 0, 0));   // newline on last row scrolls
      send_request(request_of(OP_SET, 0, 80, 30));            // both coordinates out of range
      send_request(request_of(OP_SET, 8'hff, 255, 127));
      send_request(request_of(OP_SET, 0, 5, 3));
      send_request(request_of(OP_PUT, 8'h80, 0, 0));
      send_request(request_of(OP_PUT, 8'h7f, 0, 0));
      send_request(request_of(OP_PUT, NEWLINE_CODE, 0, 0));
      send_request(request_of(OP_READ, 0, 80, 3));            // column out of range reads 0
      send_request(request_of(OP_READ, 0, 6, 127));           // row out of range reads 0
      send_request(request_of(OP_CLEAR, 8'h55, 8'haa, 8'h55));
      send_request(request_of(OP_READ, 0, 0, 29));
      send_request(request_of(OP_PUT, 8'h01, 0, 0));
      send_request(request_of(OP_READ, 8'hff, 0, 0));

      // random phases; small screens carry most of the traffic, the full
      // store only a few items since each scroll there walks all of it
      run_phase(8'd8,   8'd4,   200, 1, 10,  0,  0);
      run_phase(8'd0,   8'd0,    60, 1, 20, 67,  0);   // zero acts as one by one
      run_phase(8'd128, 8'd64,   60, 2,  5,  0, 67);
      run_phase(8'hff,  8'hff,   30, 0,  5, 29, 29);   // above maximum clamps
      run_phase(8'd16,  8'd8,   200, 1, 10, 29, 29);   // cursor now likely off screen
      run_phase(8'd3,   8'd2,   150, 1, 10, 67,  0);
      run_phase(8'd200, 8'h80,  100, 1, 10,  0, 67);   // rows wrap to zero, one row
      run_phase(8'd1,   8'd64,  100, 1, 10, 29, 29);
      run_phase(8'd40,  8'd12,  150, 1, 10,  0,  0);

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (screen.mismatches == 0 && screen.awaited_reports.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- text_terminal_cell_buffer_top.f -----
sv/ttcb_pkg.sv
sv/ttcb_if.sv
sv/ttcb_store.sv
sv/ttcb_seq.sv
sv/text_terminal_cell_buffer_top.sv
tb/tb.sv
